/* rtl/core/complex_arith_unit_assert.svh */
// Assertion macros shared by the complex arithmetic unit modules.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("complex_arith_unit assertion failed");
`define CAU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("complex_arith_unit assertion failed");
`else
`define CAU_ASSERT(lbl, prop)
`define CAU_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

/* rtl/core/cau_pkg.sv */
// Types and constants of the complex arithmetic unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none
package cau_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int PROD_W = 2 * DATA_W;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                opcode;
        logic signed [DATA_W-1:0]  a_re;
        logic signed [DATA_W-1:0]  a_im;
        logic signed [DATA_W-1:0]  b_re;
        logic signed [DATA_W-1:0]  b_im;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  res_re;
        logic signed [DATA_W-1:0]  res_im;
        t_status                   status;
    } t_out_item;

    // Classified item passed from the front end through the queue.
    typedef struct packed {
        t_op                       op;
        logic                      dz;
        logic signed [DATA_W-1:0]  a_re;
        logic signed [DATA_W-1:0]  a_im;
        logic signed [DATA_W-1:0]  b_re;
        logic signed [DATA_W-1:0]  b_im;
    } t_work;

    // Handshake between queue and back end.
    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctl;

endpackage
`default_nettype wire

/* rtl/core/cau_front.sv */
// Front end: accepts items, decodes the opcode and flags division by zero.
// Depends on cau_pkg.
`default_nettype none
module cau_front
    import cau_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_push,
    output t_work         o_push_item,
    input  wire logic     i_q_ready
);

    logic  r_valid;
    t_work r_item;
    t_work n_item;

    assign o_in_ready  = !r_valid || i_q_ready;
    assign o_push      = r_valid && i_q_ready;
    assign o_push_item = r_item;

    always_comb begin
        n_item.op   = t_op'(i_in_item.opcode);
        n_item.dz   = (t_op'(i_in_item.opcode) == OP_DIV) &&
                      (i_in_item.b_re == '0) && (i_in_item.b_im == '0);
        n_item.a_re = i_in_item.a_re;
        n_item.a_im = i_in_item.a_im;
        n_item.b_re = i_in_item.b_re;
        n_item.b_im = i_in_item.b_im;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/cau_queue.sv */
// Four-entry queue between the front end and the back end.
// Depends on cau_pkg and the assertion macro header.
`default_nettype none
module cau_queue
    import cau_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_work  i_push_item,
    output logic        o_ready,
    input  wire t_q_ctl i_ctl_pop,
    output t_q_ctl      o_ctl,
    output t_work       o_head
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_work          r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic           pop;

    assign pop         = i_ctl_pop.pop;
    assign o_ready     = r_cnt != (AW+1)'(DEPTH);
    assign o_ctl.valid = r_cnt != '0;
    assign o_ctl.pop   = pop;
    assign o_head      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

`include "complex_arith_unit_assert.svh"

    `CAU_ASSERT_IMPL(a_no_overrun, i_push && !pop, r_cnt != (AW+1)'(DEPTH))
    `CAU_ASSERT_IMPL(a_no_underrun, pop, r_cnt != '0)
    `CAU_ASSERT(a_cnt_range, r_cnt <= (AW+1)'(DEPTH))

endmodule
`default_nettype wire

/* rtl/core/cau_back.sv */
// Back end: pipelined multipliers, sign handling, a restoring divider with
// one quotient bit per stage, saturation and the output register.
// Depends on cau_pkg and the assertion macro header.
`default_nettype none
module cau_back
    import cau_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_q_ctl i_ctl,
    input  wire t_work  i_head,
    output t_q_ctl      o_ctl_pop,
    output logic        o_res_valid,
    input  wire logic   i_res_ready,
    output t_out_item   o_res_item
);

    localparam int SUM_W = PROD_W + 2;

    typedef struct packed {
        t_op                       op;
        logic                      dz;
        logic signed [PROD_W-1:0]  p_rr;
        logic signed [PROD_W-1:0]  p_ii;
        logic signed [PROD_W-1:0]  p_ri;
        logic signed [PROD_W-1:0]  p_ir;
        logic [PROD_W-1:0]         p_bb;
        logic [PROD_W-1:0]         p_cc;
        logic signed [DATA_W:0]    s_re;
        logic signed [DATA_W:0]    s_im;
    } t_prod;

    typedef struct packed {
        t_op                       op;
        logic                      dz;
        logic signed [SUM_W-1:0]   v_re;
        logic signed [SUM_W-1:0]   v_im;
        logic [PROD_W-1:0]         den;
    } t_sum;

    typedef struct packed {
        t_op                op;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic [PROD_W-1:0]  mag_re;
        logic [PROD_W-1:0]  mag_im;
        logic [PROD_W-1:0]  den;
    } t_mag;

    typedef struct packed {
        t_op                op;
        logic               dz;
        logic               neg_re;
        logic               neg_im;
        logic [PROD_W-1:0]  mag_re;
        logic [PROD_W-1:0]  mag_im;
        logic [PROD_W-1:0]  den;
        logic [PROD_W-1:0]  rem_re;
        logic [PROD_W-1:0]  rem_im;
        logic [DATA_W-1:0]  qlo_re;
        logic [DATA_W-1:0]  qlo_im;
        logic               ovf_re;
        logic               ovf_im;
    } t_div;

    // One restoring step: the next dividend bit leaves the top of qlo and the
    // quotient bit enters at its bottom, so qlo holds the quotient at the end.
    function automatic logic [PROD_W+DATA_W-1:0] div_step(
        input logic [PROD_W-1:0] rem,
        input logic [DATA_W-1:0] qlo,
        input logic [PROD_W-1:0] den
    );
        logic [PROD_W:0]   rem2;
        logic [PROD_W:0]   diff;
        logic [PROD_W-1:0] rem_n;
        logic              qbit;
        rem2 = {rem, qlo[DATA_W-1]};
        diff = rem2 - {1'b0, den};
        qbit = rem2 >= {1'b0, den};
        rem_n = qbit ? diff[PROD_W-1:0] : rem2[PROD_W-1:0];
        return {rem_n, qlo[DATA_W-2:0], qbit};
    endfunction

    // Clamp a sign and magnitude to the signed word range; top bit is the flag.
    function automatic logic [DATA_W:0] sat_enc(
        input logic              neg,
        input logic [PROD_W-1:0] mag,
        input logic              force_sat
    );
        logic [PROD_W-1:0] top;
        logic [PROD_W-1:0] m;
        logic              sat;
        logic [DATA_W-1:0] val;
        top = neg ? (PROD_W'(1) << (DATA_W-1)) : ((PROD_W'(1) << (DATA_W-1)) - 1'b1);
        sat = force_sat || (mag > top);
        m   = sat ? top : mag;
        val = neg ? (DATA_W'(0) - m[DATA_W-1:0]) : m[DATA_W-1:0];
        return {sat, val};
    endfunction

    logic      en;
    logic      r_va, r_vb, r_vc, r_vd;
    logic      r_vdv [DATA_W+1];
    t_work     r_a;
    t_prod     r_b;
    t_sum      r_c;
    t_mag      r_d;
    t_div      r_dv [DATA_W+1];
    t_prod     n_b;
    t_sum      n_c;
    t_mag      n_d;
    t_div      n_dv0;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    assign en              = !r_out_valid || i_res_ready;
    assign o_ctl_pop.pop   = en && i_ctl.valid;
    assign o_ctl_pop.valid = i_ctl.valid;
    assign o_res_valid     = r_out_valid;
    assign o_res_item      = r_out;

    // Products and the plain sums.
    always_comb begin
        n_b.op   = r_a.op;
        n_b.dz   = r_a.dz;
        n_b.p_rr = PROD_W'(r_a.a_re) * PROD_W'(r_a.b_re);
        n_b.p_ii = PROD_W'(r_a.a_im) * PROD_W'(r_a.b_im);
        n_b.p_ri = PROD_W'(r_a.a_re) * PROD_W'(r_a.b_im);
        n_b.p_ir = PROD_W'(r_a.a_im) * PROD_W'(r_a.b_re);
        n_b.p_bb = PROD_W'(r_a.b_re) * PROD_W'(r_a.b_re);
        n_b.p_cc = PROD_W'(r_a.b_im) * PROD_W'(r_a.b_im);
        if (r_a.op == OP_SUB) begin
            n_b.s_re = (DATA_W+1)'(r_a.a_re) - (DATA_W+1)'(r_a.b_re);
            n_b.s_im = (DATA_W+1)'(r_a.a_im) - (DATA_W+1)'(r_a.b_im);
        end else begin
            n_b.s_re = (DATA_W+1)'(r_a.a_re) + (DATA_W+1)'(r_a.b_re);
            n_b.s_im = (DATA_W+1)'(r_a.a_im) + (DATA_W+1)'(r_a.b_im);
        end
    end

    // Combine the products or pass on the sums; the divisor is the squared magnitude of b.
    always_comb begin
        n_c.op  = r_b.op;
        n_c.dz  = r_b.dz;
        n_c.den = r_b.p_bb + r_b.p_cc;
        unique case (r_b.op) inside
            OP_ADD, OP_SUB: begin
                n_c.v_re = SUM_W'(r_b.s_re);
                n_c.v_im = SUM_W'(r_b.s_im);
            end
            OP_MUL: begin
                n_c.v_re = SUM_W'(r_b.p_rr) - SUM_W'(r_b.p_ii);
                n_c.v_im = SUM_W'(r_b.p_ri) + SUM_W'(r_b.p_ir);
            end
            default: begin
                n_c.v_re = SUM_W'(r_b.p_rr) + SUM_W'(r_b.p_ii);
                n_c.v_im = SUM_W'(r_b.p_ir) - SUM_W'(r_b.p_ri);
            end
        endcase
    end

    // Sign and magnitude; a multiply result drops its fraction bits toward zero here.
    always_comb begin
        logic [SUM_W-1:0] abs_re;
        logic [SUM_W-1:0] abs_im;
        abs_re     = r_c.v_re[SUM_W-1] ? (SUM_W'(0) - r_c.v_re) : r_c.v_re;
        abs_im     = r_c.v_im[SUM_W-1] ? (SUM_W'(0) - r_c.v_im) : r_c.v_im;
        n_d.op     = r_c.op;
        n_d.dz     = r_c.dz;
        n_d.den    = r_c.den;
        n_d.neg_re = r_c.v_re[SUM_W-1];
        n_d.neg_im = r_c.v_im[SUM_W-1];
        if (r_c.op == OP_MUL) begin
            n_d.mag_re = abs_re[PROD_W-1:0] >> FRAC_W;
            n_d.mag_im = abs_im[PROD_W-1:0] >> FRAC_W;
        end else begin
            n_d.mag_re = abs_re[PROD_W-1:0];
            n_d.mag_im = abs_im[PROD_W-1:0];
        end
    end

    // Divider set-up: the upper dividend part must stay below the divisor,
    // otherwise the quotient does not fit in a word and saturates.
    always_comb begin
        logic [PROD_W-1:0] sh_re;
        logic [PROD_W-1:0] sh_im;
        sh_re        = r_d.mag_re << FRAC_W;
        sh_im        = r_d.mag_im << FRAC_W;
        n_dv0.op     = r_d.op;
        n_dv0.dz     = r_d.dz;
        n_dv0.neg_re = r_d.neg_re;
        n_dv0.neg_im = r_d.neg_im;
        n_dv0.mag_re = r_d.mag_re;
        n_dv0.mag_im = r_d.mag_im;
        n_dv0.den    = r_d.den;
        n_dv0.rem_re = r_d.mag_re >> (DATA_W - FRAC_W);
        n_dv0.rem_im = r_d.mag_im >> (DATA_W - FRAC_W);
        n_dv0.qlo_re = sh_re[DATA_W-1:0];
        n_dv0.qlo_im = sh_im[DATA_W-1:0];
        n_dv0.ovf_re = (r_d.mag_re >> (DATA_W - FRAC_W)) >= r_d.den;
        n_dv0.ovf_im = (r_d.mag_im >> (DATA_W - FRAC_W)) >= r_d.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va     <= 1'b0;
            r_vb     <= 1'b0;
            r_vc     <= 1'b0;
            r_vd     <= 1'b0;
            r_vdv[0] <= 1'b0;
        end else if (en) begin
            r_va     <= i_ctl.valid;
            r_vb     <= r_va;
            r_vc     <= r_vb;
            r_vd     <= r_vc;
            r_vdv[0] <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a     <= i_head;
            r_b     <= n_b;
            r_c     <= n_c;
            r_d     <= n_d;
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar k = 1; k <= DATA_W; k++) begin : g_step
        t_div n_step;

        always_comb begin
            n_step = r_dv[k-1];
            {n_step.rem_re, n_step.qlo_re} =
                div_step(r_dv[k-1].rem_re, r_dv[k-1].qlo_re, r_dv[k-1].den);
            {n_step.rem_im, n_step.qlo_im} =
                div_step(r_dv[k-1].rem_im, r_dv[k-1].qlo_im, r_dv[k-1].den);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vdv[k] <= 1'b0;
            end else if (en) begin
                r_vdv[k] <= r_vdv[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k] <= n_step;
            end
        end
    end

    always_comb begin
        logic              is_div;
        logic [DATA_W:0]   enc_re;
        logic [DATA_W:0]   enc_im;
        is_div = r_dv[DATA_W].op == OP_DIV;
        enc_re = sat_enc(r_dv[DATA_W].neg_re,
                         is_div ? PROD_W'(r_dv[DATA_W].qlo_re) : r_dv[DATA_W].mag_re,
                         is_div && r_dv[DATA_W].ovf_re);
        enc_im = sat_enc(r_dv[DATA_W].neg_im,
                         is_div ? PROD_W'(r_dv[DATA_W].qlo_im) : r_dv[DATA_W].mag_im,
                         is_div && r_dv[DATA_W].ovf_im);
        if (r_dv[DATA_W].dz) begin
            n_out.res_re = '0;
            n_out.res_im = '0;
            n_out.status = ST_DZ;
        end else begin
            n_out.res_re = enc_re[DATA_W-1:0];
            n_out.res_im = enc_im[DATA_W-1:0];
            n_out.status = (enc_re[DATA_W] || enc_im[DATA_W]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vdv[DATA_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

`include "complex_arith_unit_assert.svh"

    `CAU_ASSERT_IMPL(a_dz_zero, r_out_valid && (r_out.status == ST_DZ),
                     (r_out.res_re == '0) && (r_out.res_im == '0))
    `CAU_ASSERT_IMPL(a_status_legal, r_out_valid,
                     (r_out.status == ST_OK) || (r_out.status == ST_SAT) ||
                     (r_out.status == ST_DZ))
    `CAU_ASSERT_IMPL(a_sat_at_limit, r_out_valid && (r_out.status == ST_SAT),
                     (r_out.res_re == {1'b0, {(DATA_W-1){1'b1}}}) ||
                     (r_out.res_re == {1'b1, {(DATA_W-1){1'b0}}}) ||
                     (r_out.res_im == {1'b0, {(DATA_W-1){1'b1}}}) ||
                     (r_out.res_im == {1'b1, {(DATA_W-1){1'b0}}}))

endmodule
`default_nettype wire

/* rtl/core/complex_arith_unit.sv */
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// Q16.16 operands, with saturation and a divide-by-zero status. One item is
// accepted per clock and one result leaves per clock while the output is
// taken. An item passes one front-end register, a four-entry queue and a
// back-end pipeline of 38 registers; the depth is set by the divider, which
// resolves one quotient bit in each of its 32 stages. A stalled output holds
// the whole back end, and the queue keeps the input side accepting until its
// four entries and the front-end register are full.
// Depends on cau_pkg, cau_front, cau_queue and cau_back.
`default_nettype none
module complex_arith_unit
    import cau_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_item,
    output logic          o_res_valid,
    input  wire logic     i_res_ready,
    output t_out_item     o_res_item
);

    logic   push;
    logic   q_ready;
    t_work  push_item;
    t_work  head;
    t_q_ctl q_ctl;
    t_q_ctl pop_ctl;

    cau_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_push      (push),
        .o_push_item (push_item),
        .i_q_ready   (q_ready)
    );

    cau_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_ready     (q_ready),
        .i_ctl_pop   (pop_ctl),
        .o_ctl       (q_ctl),
        .o_head      (head)
    );

    cau_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (q_ctl),
        .i_head      (head),
        .o_ctl_pop   (pop_ctl),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_item  (o_res_item)
    );

endmodule
`default_nettype wire
